>>> src/wbp_pkg.sv
// Shared constants and payload types of the waveform bin pyramid builder.
package wbp_pkg;

    // Pyramid geometry.
    localparam int CHANNELS   = 8;
    localparam int MAX_LEVELS = 16;
    localparam int SLOTS      = CHANNELS * MAX_LEVELS;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int LVL_W      = $clog2(MAX_LEVELS);

    // Field widths.
    localparam int CH_W       = 3;
    localparam int OUT_LVL_W  = 4;
    localparam int SMP_W      = 16;
    localparam int IN_FRM_W   = 9;
    localparam int FRAME_W    = 24;
    localparam logic [FRAME_W-1:0] FRAME_SAT = {FRAME_W{1'b1}};

    // One level-0 input beat.
    typedef struct packed {
        logic [CH_W-1:0]        channel;
        logic signed [SMP_W-1:0] bin_min;
        logic signed [SMP_W-1:0] bin_max;
        logic [SMP_W-1:0]       bin_peak;
        logic [SMP_W-1:0]       bin_rms;
        logic [IN_FRM_W-1:0]    bin_frames;
    } in_bin_t;

    // One folded result beat.
    typedef struct packed {
        logic [CH_W-1:0]        out_channel;
        logic [OUT_LVL_W-1:0]   out_level;
        logic signed [SMP_W-1:0] out_min;
        logic signed [SMP_W-1:0] out_max;
        logic [SMP_W-1:0]       out_peak;
        logic [SMP_W-1:0]       out_rms;
        logic [FRAME_W-1:0]     out_frames;
        logic                   last_result;
    } out_bin_t;

    // A bin as held in the pending store.
    typedef struct packed {
        logic signed [SMP_W-1:0] mx;
        logic signed [SMP_W-1:0] mn;
        logic [SMP_W-1:0]       rms;
        logic [SMP_W-1:0]       peak;
        logic [FRAME_W-1:0]     frames;
    } pend_t;

    localparam int PEND_W = $bits(pend_t);

    // Operands of one rms combination.
    typedef struct packed {
        logic [FRAME_W-1:0] fa;
        logic [SMP_W-1:0]   ra;
        logic [FRAME_W-1:0] fb;
        logic [SMP_W-1:0]   rb;
    } rms_req_t;

endpackage

>>> src/wbp_ram.sv
// Generic single-port RAM with registered read.
module wbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/wbp_rms_unit.sv
// Serial unit for the frame-weighted rms: products, bit-serial divide, bit-serial square root.
module wbp_rms_unit
    import wbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  rms_req_t         req,
    output logic             done,
    output logic [SMP_W-1:0] rms
);

    localparam int TOT_W     = FRAME_W + 1;
    localparam int SQ_W      = 2 * SMP_W;
    localparam int PROD_W    = FRAME_W + SQ_W;
    localparam int DVD_W     = PROD_W + 1;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int BIT_W     = $clog2(SMP_W);

    typedef enum logic [7:0] {
        R_IDLE = 8'b0000_0001,
        R_SQ   = 8'b0000_0010,
        R_PA   = 8'b0000_0100,
        R_PB   = 8'b0000_1000,
        R_SUM  = 8'b0001_0000,
        R_DIV  = 8'b0010_0000,
        R_SQRT = 8'b0100_0000,
        R_DONE = 8'b1000_0000
    } rms_state_t;

    rms_state_t         state_reg;
    rms_req_t           req_reg;
    logic [TOT_W-1:0]   tot_reg;
    logic [SQ_W-1:0]    ra2_reg;
    logic [SQ_W-1:0]    rb2_reg;
    logic [PROD_W-1:0]  pa_reg;
    logic [PROD_W-1:0]  pb_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [TOT_W-1:0]   rem_reg;
    logic [SQ_W-1:0]    quo_reg;
    logic [SMP_W-1:0]   root_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [TOT_W:0]     rem_sh;
    logic [TOT_W:0]     rem_sub;
    logic               rem_ge;
    logic [SMP_W-1:0]   cand;
    logic [SQ_W-1:0]    cand_sq;

    // One restoring divide step and one square-root trial per cycle.
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
        rem_ge  = rem_sh >= {1'b0, tot_reg};
        rem_sub = rem_sh - {1'b0, tot_reg};
        cand    = root_reg | (SMP_W'(1) << cnt_reg[BIT_W-1:0]);
        cand_sq = cand * cand;
    end

    // Control and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= req;
                        tot_reg   <= TOT_W'(req.fa) + TOT_W'(req.fb);
                        state_reg <= R_SQ;
                    end
                end
                R_SQ:
                begin
                    ra2_reg   <= req_reg.ra * req_reg.ra;
                    rb2_reg   <= req_reg.rb * req_reg.rb;
                    state_reg <= R_PA;
                end
                R_PA:
                begin
                    pa_reg    <= req_reg.fa * ra2_reg;
                    state_reg <= R_PB;
                end
                R_PB:
                begin
                    pb_reg    <= req_reg.fb * rb2_reg;
                    state_reg <= R_SUM;
                end
                R_SUM:
                begin
                    dvd_reg  <= DVD_W'(pa_reg) + DVD_W'(pb_reg);
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= '0;
                    // No frames at all gives an rms of zero.
                    state_reg <= (tot_reg == '0) ? R_DONE : R_DIV;
                end
                R_DIV:
                begin
                    rem_reg <= rem_ge ? rem_sub[TOT_W-1:0] : rem_sh[TOT_W-1:0];
                    dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                    quo_reg <= {quo_reg[SQ_W-2:0], rem_ge};
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        cnt_reg   <= CNT_W'(SMP_W - 1);
                        state_reg <= R_SQRT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                R_SQRT:
                begin
                    if (cand_sq <= quo_reg)
                    begin
                        root_reg <= cand;
                    end
                    if (cnt_reg == '0)
                    begin
                        state_reg <= R_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                R_DONE:
                begin
                    state_reg <= R_IDLE;
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    assign done = (state_reg == R_DONE);
    assign rms  = root_reg;

endmodule

>>> src/waveform_bin_pyramid_builder.sv
// Top level: per-channel min/max/peak/rms pyramid built over a pending-bin RAM.
//
//  channel | beat          | handshake
//  in      | in_bin_t      | in_valid / in_ready
//  out     | out_bin_t     | out_valid / out_ready
//
// An input beat is taken only while the block is idle. Each level visited costs one
// lookup: a free slot stores the bin and ends the beat, a held bin is read and folded.
// Each fold passes a fetch step, the rms unit (squares, two products, sum, 57 divide
// steps, 16 square-root steps, done) and the output state, which waits for out_ready.
// Pending valid bits are flip-flops cleared by reset, so no clearing pass runs.
// A stalled result beat holds the block; nothing else is accepted meanwhile.
module waveform_bin_pyramid_builder
    import wbp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_bin_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output out_bin_t out_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_FETCH = 5'b00100,
        S_RMS   = 5'b01000,
        S_OUT   = 5'b10000
    } top_state_t;

    top_state_t          state_reg;
    logic [SLOTS-1:0]    valid_reg;
    pend_t               cur_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [LVL_W-1:0]    lvl_reg;
    out_bin_t            out_reg;

    logic [LVL_W-1:0]    lvl_next;
    logic [SLOT_W-1:0]   slot;
    logic [SLOT_W-1:0]   slot_next;
    logic                ram_wr;
    logic                ram_rd;
    pend_t               held;
    logic [FRAME_W:0]    tot;
    logic                rms_start;
    rms_req_t            rms_req;
    logic                rms_done;
    logic [SMP_W-1:0]    rms_val;
    logic                at_top;

    // Slot addressing for the current and the next level, RAM controls, frame total and rms request.
    always_comb
    begin
        lvl_next  = lvl_reg + 1'b1;
        slot      = SLOT_W'(SLOT_W'(ch_reg) * SLOT_W'(MAX_LEVELS) + SLOT_W'(lvl_reg));
        slot_next = SLOT_W'(SLOT_W'(ch_reg) * SLOT_W'(MAX_LEVELS) + SLOT_W'(lvl_next));
        at_top    = (lvl_next == LVL_W'(MAX_LEVELS - 1));
        ram_wr    = (state_reg == S_LOOK) && !valid_reg[slot];
        ram_rd    = (state_reg == S_LOOK) && valid_reg[slot];
        tot       = (FRAME_W + 1)'(held.frames) + (FRAME_W + 1)'(cur_reg.frames);
        rms_start = (state_reg == S_FETCH);
        rms_req   = '{fa: held.frames, ra: held.rms, fb: cur_reg.frames, rb: cur_reg.rms};
    end

    wbp_ram #(
        .WIDTH(PEND_W),
        .DEPTH(SLOTS)
    ) u_pend_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .rd_en   (ram_rd),
        .addr    (slot),
        .wr_data (cur_reg),
        .rd_data (held)
    );

    wbp_rms_unit u_rms (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rms_start),
        .req   (rms_req),
        .done  (rms_done),
        .rms   (rms_val)
    );

    // Sequencer: look up each level, fold, emit, climb.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ch_reg  <= in_data.channel;
                        lvl_reg <= '0;
                        cur_reg <= '{mx: in_data.bin_max, mn: in_data.bin_min,
                                     rms: in_data.bin_rms, peak: in_data.bin_peak,
                                     frames: FRAME_W'(in_data.bin_frames)};
                        // A channel beyond the pyramid count is dropped.
                        if (int'(in_data.channel) < CHANNELS)
                        begin
                            state_reg <= S_LOOK;
                        end
                    end
                end
                S_LOOK:
                begin
                    valid_reg[slot] <= !valid_reg[slot];
                    state_reg       <= valid_reg[slot] ? S_FETCH : S_IDLE;
                end
                S_FETCH:
                begin
                    cur_reg.mn     <= (held.mn <= cur_reg.mn) ? held.mn : cur_reg.mn;
                    cur_reg.mx     <= (held.mx >= cur_reg.mx) ? held.mx : cur_reg.mx;
                    cur_reg.peak   <= (held.peak >= cur_reg.peak) ? held.peak : cur_reg.peak;
                    cur_reg.frames <= (tot > (FRAME_W + 1)'(FRAME_SAT)) ? FRAME_SAT
                                                                         : tot[FRAME_W-1:0];
                    state_reg      <= S_RMS;
                end
                S_RMS:
                begin
                    if (rms_done)
                    begin
                        cur_reg.rms <= rms_val;
                        out_reg     <= '{out_channel: ch_reg,
                                         out_level:   OUT_LVL_W'(lvl_next),
                                         out_min:     cur_reg.mn,
                                         out_max:     cur_reg.mx,
                                         out_peak:    cur_reg.peak,
                                         out_rms:     rms_val,
                                         out_frames:  cur_reg.frames,
                                         last_result: at_top || !valid_reg[slot_next]};
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        lvl_reg   <= lvl_next;
                        // A bin built at the top level is emitted and dropped.
                        state_reg <= at_top ? S_IDLE : S_LOOK;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_reg;

endmodule

>>> src/wbp_checker.sv
// Port-level checks of the pyramid builder, bound to the top level.
module wbp_checker
    import wbp_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input out_bin_t out_data
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // The block never takes an input while a result is waiting.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    // An accepted input cannot produce a result in the very next cycle.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result appeared too early");

    // A folded bin is never level zero.
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.out_level != '0)
        else $error("result at level zero");

endmodule

bind waveform_bin_pyramid_builder wbp_checker u_wbp_checker (.*);

>>> tb/sv/testbench.sv
// Testbench for the waveform bin pyramid builder: directed table, random bins, fold predictor.
`timescale 1ns / 100ps

module testbench;
    import wbp_pkg::*;

    localparam int IN_W = $bits(in_bin_t);

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    in_bin_t  in_data;
    logic     out_valid;
    logic     out_ready;
    out_bin_t out_data;

    // Predictor state: one pending bin per channel and level.
    logic   pend_ok [SLOTS];
    pend_t  pend_bin [SLOTS];

    out_bin_t folds_due [$];
    int       err_count;
    int       accepted;
    int       last_folds;     // folds caused by the most recent accepted beat
    bit       hold_mode;      // receiver holds off for a long stretch
    bit       quiet_mode;     // no idling on either side

    // Directed stimulus row; want_n < 0 means use the predictor only.
    typedef struct {
        in_bin_t  bin;
        int       want_n;
        out_bin_t want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    waveform_bin_pyramid_builder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Floor integer square root, bit by bit.
    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Fold two bins as the block does.
    function automatic pend_t fold_pair(pend_t a, pend_t b);
        pend_t       o;
        logic [63:0] tot;
        logic [63:0] sq;
        o.mn   = (a.mn <= b.mn) ? a.mn : b.mn;
        o.mx   = (a.mx >= b.mx) ? a.mx : b.mx;
        o.peak = (a.peak >= b.peak) ? a.peak : b.peak;
        tot = 64'(a.frames) + 64'(b.frames);
        sq  = 64'(a.frames) * 64'(a.rms) * 64'(a.rms)
            + 64'(b.frames) * 64'(b.rms) * 64'(b.rms);
        o.rms    = (tot != 0) ? SMP_W'(int_sqrt(sq / tot)) : '0;
        o.frames = (tot > 64'(FRAME_SAT)) ? FRAME_SAT : tot[FRAME_W-1:0];
        return o;
    endfunction

    // Walk one bin up its channel pyramid and queue every fold it causes.
    function automatic int predict_folds(in_bin_t b);
        pend_t    cur;
        out_bin_t r;
        int       n;
        int       s;
        n = 0;
        if (int'(b.channel) >= CHANNELS)
            return 0;
        cur.mn = b.bin_min;
        cur.mx = b.bin_max;
        cur.peak = b.bin_peak;
        cur.rms = b.bin_rms;
        cur.frames = FRAME_W'(b.bin_frames);
        for (int lvl = 0; lvl + 1 < MAX_LEVELS; lvl++)
        begin
            s = int'(b.channel) * MAX_LEVELS + lvl;
            if (!pend_ok[s])
            begin
                pend_ok[s]  = 1'b1;
                pend_bin[s] = cur;
                break;
            end
            pend_ok[s] = 1'b0;
            cur = fold_pair(pend_bin[s], cur);
            r.out_channel = b.channel;
            r.out_level   = OUT_LVL_W'(lvl + 1);
            r.out_min     = cur.mn;
            r.out_max     = cur.mx;
            r.out_peak    = cur.peak;
            r.out_rms     = cur.rms;
            r.out_frames  = cur.frames;
            r.last_result = 1'b0;
            folds_due = {folds_due, r};
            n++;
        end
        if (n > 0)
            folds_due[folds_due.size() - 1].last_result = 1'b1;
        return n;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic in_bin_t make_bin(int ch, int mn, int mx, int pk, int rm, int fr);
        in_bin_t b;
        b.channel = CH_W'(ch);
        b.bin_min = SMP_W'(mn);
        b.bin_max = SMP_W'(mx);
        b.bin_peak = SMP_W'(pk);
        b.bin_rms = SMP_W'(rm);
        b.bin_frames = IN_FRM_W'(fr);
        return b;
    endfunction

    function automatic in_bin_t rand_bin(int ch);
        in_bin_t b;
        b = IN_W'({$urandom(), $urandom(), $urandom()});
        b.channel = CH_W'(ch);
        if ($urandom_range(0, 3) != 0)
            b.bin_frames = ($urandom_range(0, 7) == 0) ? IN_FRM_W'($urandom_range(0, 511))
                                                         : IN_FRM_W'(256);
        return b;
    endfunction

    // Send one beat; the predictor runs on acceptance.
    task automatic send_bin(in_bin_t b);
        while (!quiet_mode && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        last_folds = predict_folds(b);
        accepted++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (folds_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Receiver: random idling, optionally a long hold-off.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_mode)
            begin
                out_ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_mode = 1'b0;
            end
            out_ready <= quiet_mode || ($urandom_range(0, 99) >= 20);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        out_bin_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (folds_due.size() == 0)
                report_mismatch("unexpected beat", 64'(out_data), 64'(0));
            else
            begin
                w = folds_due.pop_front();
                if (out_data.out_channel !== w.out_channel)
                    report_mismatch("channel", 64'(out_data.out_channel), 64'(w.out_channel));
                if (out_data.out_level !== w.out_level)
                    report_mismatch("level", 64'(out_data.out_level), 64'(w.out_level));
                if (out_data.out_min !== w.out_min)
                    report_mismatch("min", 64'(out_data.out_min), 64'(w.out_min));
                if (out_data.out_max !== w.out_max)
                    report_mismatch("max", 64'(out_data.out_max), 64'(w.out_max));
                if (out_data.out_peak !== w.out_peak)
                    report_mismatch("peak", 64'(out_data.out_peak), 64'(w.out_peak));
                if (out_data.out_rms !== w.out_rms)
                    report_mismatch("rms", 64'(out_data.out_rms), 64'(w.out_rms));
                if (out_data.out_frames !== w.out_frames)
                    report_mismatch("frames", 64'(out_data.out_frames), 64'(w.out_frames));
                if (out_data.last_result !== w.last_result)
                    report_mismatch("last", 64'(out_data.last_result), 64'(w.last_result));
            end
        end
    end

    // Main sequence.
    initial
    begin
        dir_row_t row;
        int       ch;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        err_count = 0;
        accepted = 0;
        last_folds = 0;
        hold_mode = 1'b0;
        quiet_mode = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            pend_ok[i] = 1'b0;
            pend_bin[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: extremes, zero frames, unsigned compares.
        row.want_n = 0;
        row.want = '0;
        row.bin = make_bin(0, -32768, 32767, 32768, 32768, 256);
        dir_rows = {dir_rows, row};
        row.want_n = 1;
        row.want.out_channel = CH_W'(0);
        row.want.out_level = OUT_LVL_W'(1);
        row.want.out_min = SMP_W'(-32768);
        row.want.out_max = SMP_W'(32767);
        row.want.out_peak = 16'hFFFF;
        row.want.out_rms = SMP_W'(32768);
        row.want.out_frames = FRAME_W'(512);
        row.want.last_result = 1'b1;
        row.bin = make_bin(0, 32767, -32768, 16'hFFFF, 32768, 256);
        dir_rows = {dir_rows, row};
        row.want_n = 0;
        row.bin = make_bin(1, 5, 6, 7, 100, 0);
        dir_rows = {dir_rows, row};
        row.want_n = 1;
        row.want = '0;
        row.want.out_channel = CH_W'(1);
        row.want.out_level = OUT_LVL_W'(1);
        row.want.out_min = SMP_W'(5);
        row.want.out_max = SMP_W'(6);
        row.want.out_peak = SMP_W'(7);
        row.want.last_result = 1'b1;
        row.bin = make_bin(1, 5, 6, 7, 16'hFFFF, 0);
        dir_rows = {dir_rows, row};
        row.want_n = -1;
        for (int i = 0; i < 8; i++)
        begin
            row.bin = make_bin(7, -i, i, i, 16'hFFFF, 511);
            dir_rows = {dir_rows, row};
        end
        for (int i = 0; i < 8; i++)
        begin
            row.bin = make_bin(i, 0, 0, 0, 0, i * 73);
            dir_rows = {dir_rows, row};
        end
        foreach (dir_rows[k])
        begin
            row = dir_rows[k];
            send_bin(row.bin);
            if (row.want_n >= 0)
            begin
                if (last_folds != row.want_n)
                    report_mismatch("fold count", 64'(last_folds), 64'(row.want_n));
                else if (row.want_n == 1 && folds_due[folds_due.size() - 1] != row.want)
                    report_mismatch("table row", 64'(k), 64'(k));
            end
        end

        // Long run of one channel for deep folds, without idling.
        wait_drained();
        quiet_mode = 1'b1;
        for (int i = 0; i < 128; i++)
            send_bin(rand_bin(3));
        quiet_mode = 1'b0;
        wait_drained();

        // Receiver holds off while the sender keeps offering.
        hold_mode = 1'b1;
        for (int i = 0; i < 60; i++)
            send_bin(rand_bin($urandom_range(0, 1)));

        // Random part, biased to few channels so deeper folds show up.
        for (int i = 0; i < 150; i++)
        begin
            ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 1);
            send_bin(rand_bin(ch));
            if (i == 75)
                wait_drained();
        end

        wait_drained();
        if (folds_due.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("** waveform_bin_pyramid_builder: PASSED **");
        else
            $display("** waveform_bin_pyramid_builder: FAILED **");
        $finish;
    end

    // Overall time limit.
    initial
    begin
        #400ms;
        $display("** waveform_bin_pyramid_builder: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
src/wbp_pkg.sv
src/wbp_ram.sv
src/wbp_rms_unit.sv
src/waveform_bin_pyramid_builder.sv
src/wbp_checker.sv
tb/sv/testbench.sv
